[rtl/sst_pkg.sv]
// Package for the stereo sine tone sample core: widths, register indexes,
// the shared pipeline tag, the reciprocal for the volume divide and the sine table function.
// Used by every file in rtl; it depends on nothing else.
package sst_pkg;

  localparam int unsigned PhaseBitsDefault = 12;

  localparam int unsigned FrameW    = 32;
  localparam int unsigned FreqW     = 16;
  localparam int unsigned RateW     = 18;
  localparam int unsigned VolW      = 8;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned ProdW     = FreqW + FrameW;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = RateW;

  localparam int unsigned SineW     = 15;
  localparam int unsigned VolClampW = 7;
  localparam int unsigned ScaledW   = SineW + VolClampW;
  localparam int unsigned RecipW    = 30;
  localparam int unsigned RecipProdW = ScaledW + RecipW;

  // Restoring division steps done per pipeline stage.
  localparam int unsigned StepsPerStage = 4;

  localparam logic [RateW-1:0]     SampleRateReset = 18'd48000;
  localparam logic [VolClampW-1:0] VolMax          = 7'd100;

  // floor(n / 100) == (n * RecipMul) >> RecipShift for every n below 2^22.
  localparam logic [RecipW-1:0] RecipMul   = 30'd687194768;
  localparam int unsigned       RecipShift = 36;

  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint OneQ30    = 64'sd1073741824;

  // Entry k is ceil(2^41 / ((2k)(2k+1))). Multiplying by it and shifting right by 41
  // gives the exact floor of the Taylor term divide, because every term stays below 2^33.
  localparam int unsigned TaylorShift = 41;
  localparam logic [7:1][63:0] TaylorRecip = {
    ((64'd1 << TaylorShift) / 64'd210) + 64'd1,
    ((64'd1 << TaylorShift) / 64'd156) + 64'd1,
    ((64'd1 << TaylorShift) / 64'd110) + 64'd1,
    ((64'd1 << TaylorShift) / 64'd72) + 64'd1,
    ((64'd1 << TaylorShift) / 64'd42) + 64'd1,
    ((64'd1 << TaylorShift) / 64'd20) + 64'd1,
    ((64'd1 << TaylorShift) / 64'd6) + 64'd1
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgSampleRate = 2'd0,
    CfgToneFreq   = 2'd1,
    CfgVolume     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  function automatic int unsigned div_stages(input int unsigned phase_bits);
    return (ProdW + phase_bits + StepsPerStage - 1) / StepsPerStage;
  endfunction

  // Edges from the accepting edge to the edge at which the result is taken.
  function automatic int unsigned pipe_latency(input int unsigned phase_bits);
    return div_stages(phase_bits) + 5;
  endfunction

  // Quarter-wave sine with amplitude 32767, evaluated as a truncated Taylor series
  // in Q2.30. Only called with constant arguments to build the sine ROM.
  function automatic logic [SineW-1:0] quarter_sine(input int unsigned q,
                                                   input int unsigned qshift);
    longint       x;
    longint       x2;
    longint       term;
    longint       sum;
    longint       r;
    logic [127:0] quot;
    x    = (longint'(q) * HalfPiQ30) >> qshift;
    x2   = (x * x) / OneQ30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 7; k++) begin
      term = (term * x2) / OneQ30;
      quot = 128'(term) * 128'(TaylorRecip[k]);
      term = longint'(quot >> TaylorShift);
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (r > 32767) begin
      r = 32767;
    end
    return r[SineW-1:0];
  endfunction

endpackage

[rtl/sst_phase_div.sv]
// Pipelined restoring divider that turns frequency * frame into the quantized tone phase.
// Depends on sst_pkg for widths, the step count per stage and the pipeline tag.
module sst_phase_div #(
  parameter int unsigned PhaseBits = sst_pkg::PhaseBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sst_pkg::tag_t             tag_i,
  input  logic [sst_pkg::ProdW-1:0] product_i,
  input  logic [sst_pkg::RateW-1:0] divisor_i,
  output sst_pkg::tag_t             tag_o,
  output logic [PhaseBits-1:0]      phase_o
);
  import sst_pkg::*;

  localparam int unsigned NumStages = div_stages(PhaseBits);
  localparam int unsigned WordW     = NumStages * StepsPerStage;

  // The word holds the dividend bits still to be shifted in at the top and the
  // quotient bits collected so far at the bottom. The dividend is product * 2^PhaseBits,
  // so the low PhaseBits quotient bits are floor((product mod d) * 2^PhaseBits / d).
  logic [WordW-1:0] word_q [NumStages];
  logic [RateW-1:0] rem_q  [NumStages];
  tag_t             tag_q  [NumStages];

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic [WordW-1:0] word_in;
    logic [RateW-1:0] rem_in;
    tag_t             tag_in;
    logic [WordW-1:0] word_d;
    logic [RateW-1:0] rem_d;

    if (s == 0) begin : g_first
      assign word_in = WordW'({product_i, PhaseBits'(0)});
      assign rem_in  = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign word_in = word_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign tag_in  = tag_q[s-1];
    end

    always_comb begin
      logic [RateW:0] trial;
      word_d = word_in;
      rem_d  = rem_in;
      trial  = '0;
      for (int unsigned k = 0; k < StepsPerStage; k++) begin
        trial  = {rem_d, word_d[WordW-1]};
        word_d = {word_d[WordW-2:0], 1'b0};
        if (trial >= {1'b0, divisor_i}) begin
          trial     = trial - {1'b0, divisor_i};
          word_d[0] = 1'b1;
        end
        rem_d = trial[RateW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else begin
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      word_q[s] <= word_d;
      rem_q[s]  <= rem_d;
    end
  end

  assign tag_o   = tag_q[NumStages-1];
  assign phase_o = word_q[NumStages-1][PhaseBits-1:0];

endmodule

[rtl/stereo_sine_tone_sample_core.sv]
// Top level of the stereo sine tone sample core: configuration registers, product stage,
// phase divider, quarter-wave sine ROM, volume scaling and the output register.
// Depends on sst_pkg and sst_phase_div.

// The core takes one request per clock and never raises busy. A request carries an absolute
// frame number; the frame's stereo sample appears with strobe for one cycle and is taken
// at the edge that ends that cycle. The pipeline is made up of the restoring divider,
// which resolves four quotient bits per stage, plus one stage each for the
// frequency multiply, the sine ROM read, the two volume multiplies and the output.
// The receiver cannot hold results off, so every request yields exactly one strobe.
// Write the configuration registers only while no request is in flight.
module stereo_sine_tone_sample_core #(
  parameter int unsigned PhaseBits = sst_pkg::PhaseBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [sst_pkg::FrameW-1:0]          frame_index_i,
  input  logic                                last_frame_i,
  input  logic                                cfg_we_i,
  input  logic [sst_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [sst_pkg::CfgDataW-1:0]        cfg_data_i,
  output logic                                strobe,
  output logic signed [sst_pkg::SampleW-1:0]  left_sample_o,
  output logic signed [sst_pkg::SampleW-1:0]  right_sample_o,
  output logic                                last_out_o
);
  import sst_pkg::*;

  localparam int unsigned QBits = PhaseBits - 2;
  localparam int unsigned QSize = 1 << QBits;
  localparam int unsigned AddrW = PhaseBits - 1;

  // Configuration registers.
  logic [RateW-1:0] sample_rate_q;
  logic [FreqW-1:0] tone_freq_q;
  logic [VolW-1:0]  volume_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= SampleRateReset;
      tone_freq_q   <= '0;
      volume_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSampleRate: sample_rate_q <= cfg_data_i[RateW-1:0];
        CfgToneFreq:   tone_freq_q   <= cfg_data_i[FreqW-1:0];
        CfgVolume:     volume_q      <= cfg_data_i[VolW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Product stage.
  tag_t             prod_tag_q;
  logic [ProdW-1:0] product_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_tag_q <= '0;
    end else begin
      prod_tag_q.valid <= start && !busy;
      prod_tag_q.last  <= last_frame_i;
    end
  end

  always_ff @(posedge clk_i) begin
    product_q <= ProdW'(tone_freq_q) * ProdW'(frame_index_i);
  end

  // Phase division.
  tag_t                 div_tag;
  logic [PhaseBits-1:0] phase;

  sst_phase_div #(
    .PhaseBits(PhaseBits)
  ) u_phase_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (prod_tag_q),
    .product_i(product_q),
    .divisor_i(sample_rate_q),
    .tag_o    (div_tag),
    .phase_o  (phase)
  );

  // Quadrant folding onto the quarter-wave table, which holds QSize + 1 entries.
  logic [1:0]       quadrant;
  logic [QBits-1:0] quarter_idx;
  logic [AddrW-1:0] rom_addr;

  assign quadrant    = phase[PhaseBits-1 -: 2];
  assign quarter_idx = phase[QBits-1:0];
  assign rom_addr    = quadrant[0] ? (AddrW'(QSize) - AddrW'(quarter_idx))
                                   : AddrW'(quarter_idx);

  logic [SineW-1:0] sine_rom [QSize+1];

  for (genvar g = 0; g <= QSize; g++) begin : g_rom
    assign sine_rom[g] = quarter_sine(g, QBits);
  end

  tag_t             rom_tag_q;
  logic [SineW-1:0] sine_q;
  logic             rom_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_tag_q <= '0;
    end else begin
      rom_tag_q <= div_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    sine_q    <= sine_rom[rom_addr];
    rom_neg_q <= quadrant[1];
  end

  // Volume scaling: |S| * v, then the divide by 100 as a reciprocal multiply.
  logic [VolClampW-1:0] vol_clamp;

  assign vol_clamp = (volume_q > VolW'(VolMax)) ? VolMax : volume_q[VolClampW-1:0];

  tag_t               scale_tag_q;
  logic [ScaledW-1:0] scaled_q;
  logic               scale_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_tag_q <= '0;
    end else begin
      scale_tag_q <= rom_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    scaled_q    <= ScaledW'(sine_q) * ScaledW'(vol_clamp);
    scale_neg_q <= rom_neg_q;
  end

  tag_t                  recip_tag_q;
  logic [RecipProdW-1:0] recip_q;
  logic                  recip_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_tag_q <= '0;
    end else begin
      recip_tag_q <= scale_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    recip_q     <= RecipProdW'(scaled_q) * RecipProdW'(RecipMul);
    recip_neg_q <= scale_neg_q;
  end

  // Output register. A zero rate, frequency or volume forces silence.
  logic                      silent;
  logic signed [SampleW-1:0] magnitude;
  logic signed [SampleW-1:0] sample_d;
  logic signed [SampleW-1:0] sample_q;
  tag_t                      out_tag_q;

  assign silent    = (sample_rate_q == '0) || (tone_freq_q == '0) || (vol_clamp == '0);
  assign magnitude = SampleW'(recip_q[RecipShift +: SineW]);

  always_comb begin
    if (silent) begin
      sample_d = '0;
    end else if (recip_neg_q) begin
      sample_d = -magnitude;
    end else begin
      sample_d = magnitude;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_tag_q <= '0;
    end else begin
      out_tag_q <= recip_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  assign strobe         = out_tag_q.valid;
  assign last_out_o     = out_tag_q.last;
  assign left_sample_o  = sample_q;
  assign right_sample_o = sample_q;

endmodule

[rtl/sst_checker.sv]
// Port-level checks for the stereo sine tone sample core, with the bind that attaches them.
// Depends on sst_pkg for the pipeline latency.
module sst_checker #(
  parameter int unsigned PhaseBits = sst_pkg::PhaseBitsDefault
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               last_frame_i,
  input logic                               strobe,
  input logic signed [sst_pkg::SampleW-1:0] left_sample_o,
  input logic signed [sst_pkg::SampleW-1:0] right_sample_o,
  input logic                               last_out_o
);
  import sst_pkg::*;

  localparam int unsigned Latency = pipe_latency(PhaseBits);

  // Every accepted request gives a result after the fixed pipeline latency.
  a_request_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency strobe)
    else $error("accepted request produced no result at the expected latency");

  // No result appears without a request accepted the pipeline latency earlier.
  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> $past(start && !busy, Latency))
    else $error("result without a matching request");

  // The last-frame flag travels with its own request.
  a_last_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency (last_out_o == $past(last_frame_i, Latency)))
    else $error("last flag does not match its request");

  // Both channels carry the same sample, never the most negative code.
  a_channels_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> ((left_sample_o == right_sample_o) && (left_sample_o != 16'sh8000)))
    else $error("channel samples differ or are out of range");

endmodule

bind stereo_sine_tone_sample_core sst_checker #(
  .PhaseBits(PhaseBits)
) u_sst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .last_frame_i  (last_frame_i),
  .strobe        (strobe),
  .left_sample_o (left_sample_o),
  .right_sample_o(right_sample_o),
  .last_out_o    (last_out_o)
);
